@@ design/segment_intersection_2d_core_macros.svh @@
// ----------------------------------------------------------------------------
// segment intersection core assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_2D_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SGI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SGI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sgi_pkg.sv @@
// ----------------------------------------------------------------------------
// sgi_pkg
// widths and constants of the 2d segment intersection datapath
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int CW   = 32;          // coordinate width
    localparam int DW   = CW + 1;      // coordinate difference
    localparam int PW   = 2 * DW;      // product of two differences
    localparam int TW   = PW + 1;      // determinant
    localparam int LOW  = DW + 1;      // low split of a determinant
    localparam int HIW  = TW - LOW;    // high split of a determinant
    localparam int MW   = 31;          // margin register
    localparam int FW   = 32;          // margin fraction bits
    localparam int XW   = DW + TW;     // coordinate times determinant
    localparam int QW   = CW + 1;      // quotient bits kept before saturation
    localparam int DNW  = TW + 1;      // doubled denominator
    localparam int RW   = XW + 2;      // divider remainder
    localparam int SW   = CW + 3;      // final sum before saturation
    localparam int NIN  = 8;           // input coordinates per beat

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [TW-1:0] t_det;
    typedef logic signed [XW-1:0] t_wide;
    typedef logic        [RW-1:0] t_rem;

    typedef struct packed {
        logic   par;
        logic   hit;
        t_coord ax0;
        t_coord ay0;
    } t_side;

endpackage

@@ design/segment_intersection_2d_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_2d_core
// 2d segment intersection by cramer's rule with margin test and saturated
// crossing point
// ----------------------------------------------------------------------------
// slave stream: one beat carries both segments, eight signed Q16.16 coords.
// master stream: one beat per input beat, flags in tuser, point in tdata.
// config channel: a write of i_cfg_data sets the endpoint margin; it is
// always ready. the user must write it only while no beat is in flight;
// the core itself does not enforce this. an accepted input beat passes through
// eight datapath stages (differences, 33x33 products, determinants, sign
// normalize, split products, recombine, magnitudes, window test) then a
// 33-stage rounding divider, one quotient bit per stage, and a result
// stage. throughput is one beat per cycle while the master side does not stall.
// the whole pipe advances together whenever the output register is empty
// or taken; while the master side stalls with a result waiting, the slave
// side is not ready and nothing inside moves, so no beat is lost or doubled.
// a synchronous reset clears all valid bits and the margin register.
// ----------------------------------------------------------------------------
module segment_intersection_2d_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [sgi_pkg::NIN*sgi_pkg::CW-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // cross_x, cross_y
    output logic [2*sgi_pkg::CW-1:0]       o_m_axis_tdata,
    // hit, parallel
    output logic [1:0]                     o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sgi_pkg::MW-1:0]         i_cfg_data
);

    `include "segment_intersection_2d_core_macros.svh"

    localparam int CW  = sgi_pkg::CW;
    localparam int DW  = sgi_pkg::DW;
    localparam int PW  = sgi_pkg::PW;
    localparam int TW  = sgi_pkg::TW;
    localparam int LOW = sgi_pkg::LOW;
    localparam int XW  = sgi_pkg::XW;
    localparam int RW  = sgi_pkg::RW;
    localparam int DNW = sgi_pkg::DNW;
    localparam int QW  = sgi_pkg::QW;
    localparam int FW  = sgi_pkg::FW;
    localparam int MW  = sgi_pkg::MW;
    localparam int ND  = QW + 1;        // divider latency
    localparam int NST = 8 + ND;        // total pipe depth

    logic               w_adv;
    logic [NST-1:0]     r_v;
    logic [MW-1:0]      r_margin;

    assign w_adv           = !r_v[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_margin <= '0;
        end else begin
            if (w_adv) begin
                r_v <= {r_v[NST-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    sgi_pkg::t_coord w_in [sgi_pkg::NIN];
    for (genvar f = 0; f < sgi_pkg::NIN; f++) begin : g_fld
        assign w_in[f] = $signed(i_s_axis_tdata[f*CW +: CW]);
    end

    // stage 1: differences
    sgi_pkg::t_diff  r_s1_dax, r_s1_day, r_s1_dbx, r_s1_dby, r_s1_wx, r_s1_wy;
    sgi_pkg::t_coord r_s1_ax0, r_s1_ay0, r_s1_bx0;
    // stage 2: products
    sgi_pkg::t_prod  r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4, r_s2_p5, r_s2_p6;
    sgi_pkg::t_diff  r_s2_dbx, r_s2_day;
    sgi_pkg::t_coord r_s2_ax0, r_s2_ay0, r_s2_bx0;
    // stage 3: determinants
    sgi_pkg::t_det   r_s3_den, r_s3_na, r_s3_nb;
    sgi_pkg::t_diff  r_s3_dbx, r_s3_day;
    sgi_pkg::t_coord r_s3_ax0, r_s3_ay0, r_s3_bx0;
    // stage 4: positive denominator
    sgi_pkg::t_det   r_s4_den, r_s4_na, r_s4_nb;
    logic            r_s4_par;
    sgi_pkg::t_diff  r_s4_dbx, r_s4_day;
    sgi_pkg::t_coord r_s4_ax0, r_s4_ay0, r_s4_bx0;
    // stage 5: split products
    logic signed [DW+LOW:0]    r_s5_pxl, r_s5_pyl;
    logic signed [PW-1:0]      r_s5_pxh, r_s5_pyh;
    logic [MW+LOW-1:0]         r_s5_ml;
    logic [MW+sgi_pkg::HIW-1:0] r_s5_mh;
    sgi_pkg::t_det   r_s5_den, r_s5_na, r_s5_nb;
    logic            r_s5_par;
    sgi_pkg::t_coord r_s5_ax0, r_s5_ay0, r_s5_bx0;
    // stage 6: recombined
    sgi_pkg::t_wide  r_s6_px, r_s6_py, r_s6_mden;
    sgi_pkg::t_det   r_s6_den, r_s6_na, r_s6_nb;
    logic            r_s6_par;
    sgi_pkg::t_coord r_s6_ax0, r_s6_ay0, r_s6_bx0;
    // stage 7: magnitudes and upper window bound
    sgi_pkg::t_wide  r_s7_ax, r_s7_ay, r_s7_mden, r_s7_hlim;
    logic            r_s7_nx, r_s7_ny;
    sgi_pkg::t_det   r_s7_den, r_s7_na, r_s7_nb;
    logic            r_s7_par;
    sgi_pkg::t_coord r_s7_ax0, r_s7_ay0, r_s7_bx0;
    // stage 8: window test and divider operands
    sgi_pkg::t_rem   r_s8_numx, r_s8_numy;
    logic [DNW-1:0]  r_s8_d;
    logic            r_s8_nx, r_s8_ny, r_s8_ox, r_s8_oy;
    sgi_pkg::t_side  r_s8_side;
    sgi_pkg::t_coord r_s8_bx0;

    sgi_pkg::t_det   w_den_raw;
    logic            w_dneg;
    sgi_pkg::t_wide  w_sna, w_snb;
    sgi_pkg::t_rem   w_numx, w_numy, w_dlim;
    logic [DNW-1:0]  w_d;

    assign w_den_raw = r_s3_den;
    assign w_dneg    = w_den_raw[TW-1];

    assign w_sna  = XW'(r_s7_na) <<< FW;
    assign w_snb  = XW'(r_s7_nb) <<< FW;
    assign w_d    = DNW'(r_s7_den) << 1;
    assign w_numx = (RW'(r_s7_ax) << 1) + RW'(r_s7_den);
    assign w_numy = (RW'(r_s7_ay) << 1) + RW'(r_s7_den);
    assign w_dlim = RW'(w_d) << QW;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_dax <= DW'(w_in[2]) - DW'(w_in[0]);
            r_s1_day <= DW'(w_in[3]) - DW'(w_in[1]);
            r_s1_dbx <= DW'(w_in[6]) - DW'(w_in[4]);
            r_s1_dby <= DW'(w_in[7]) - DW'(w_in[5]);
            r_s1_wx  <= DW'(w_in[4]) - DW'(w_in[0]);
            r_s1_wy  <= DW'(w_in[5]) - DW'(w_in[1]);
            r_s1_ax0 <= w_in[0];
            r_s1_ay0 <= w_in[1];
            r_s1_bx0 <= w_in[4];

            r_s2_p1  <= PW'(r_s1_dax) * PW'(r_s1_dby);
            r_s2_p2  <= PW'(r_s1_dbx) * PW'(r_s1_day);
            r_s2_p3  <= PW'(r_s1_wx)  * PW'(r_s1_dby);
            r_s2_p4  <= PW'(r_s1_dbx) * PW'(r_s1_wy);
            r_s2_p5  <= PW'(r_s1_dax) * PW'(r_s1_wy);
            r_s2_p6  <= PW'(r_s1_wx)  * PW'(r_s1_day);
            r_s2_dbx <= r_s1_dbx;
            r_s2_day <= r_s1_day;
            r_s2_ax0 <= r_s1_ax0;
            r_s2_ay0 <= r_s1_ay0;
            r_s2_bx0 <= r_s1_bx0;

            r_s3_den <= TW'(r_s2_p2) - TW'(r_s2_p1);
            r_s3_na  <= TW'(r_s2_p4) - TW'(r_s2_p3);
            r_s3_nb  <= TW'(r_s2_p5) - TW'(r_s2_p6);
            r_s3_dbx <= r_s2_dbx;
            r_s3_day <= r_s2_day;
            r_s3_ax0 <= r_s2_ax0;
            r_s3_ay0 <= r_s2_ay0;
            r_s3_bx0 <= r_s2_bx0;

            // flip all three so the denominator is positive
            r_s4_den <= w_dneg ? -w_den_raw : w_den_raw;
            r_s4_na  <= w_dneg ? -r_s3_na : r_s3_na;
            r_s4_nb  <= w_dneg ? -r_s3_nb : r_s3_nb;
            r_s4_par <= (w_den_raw == '0);
            r_s4_dbx <= r_s3_dbx;
            r_s4_day <= r_s3_day;
            r_s4_ax0 <= r_s3_ax0;
            r_s4_ay0 <= r_s3_ay0;
            r_s4_bx0 <= r_s3_bx0;

            r_s5_pxl <= (DW+LOW+1)'(r_s4_dbx)
                        * $signed({1'b0, r_s4_nb[LOW-1:0]});
            r_s5_pxh <= PW'(r_s4_dbx) * PW'($signed(r_s4_nb[TW-1:LOW]));
            r_s5_pyl <= (DW+LOW+1)'(r_s4_day)
                        * $signed({1'b0, r_s4_na[LOW-1:0]});
            r_s5_pyh <= PW'(r_s4_day) * PW'($signed(r_s4_na[TW-1:LOW]));
            r_s5_ml  <= (MW+LOW)'(r_margin) * (MW+LOW)'(r_s4_den[LOW-1:0]);
            r_s5_mh  <= (MW+sgi_pkg::HIW)'(r_margin)
                        * (MW+sgi_pkg::HIW)'(r_s4_den[TW-1:LOW]);
            r_s5_den <= r_s4_den;
            r_s5_na  <= r_s4_na;
            r_s5_nb  <= r_s4_nb;
            r_s5_par <= r_s4_par;
            r_s5_ax0 <= r_s4_ax0;
            r_s5_ay0 <= r_s4_ay0;
            r_s5_bx0 <= r_s4_bx0;

            r_s6_px   <= (XW'(r_s5_pxh) <<< LOW) + XW'(r_s5_pxl);
            r_s6_py   <= (XW'(r_s5_pyh) <<< LOW) + XW'(r_s5_pyl);
            r_s6_mden <= $signed((XW'(r_s5_mh) << LOW) + XW'(r_s5_ml));
            r_s6_den  <= r_s5_den;
            r_s6_na   <= r_s5_na;
            r_s6_nb   <= r_s5_nb;
            r_s6_par  <= r_s5_par;
            r_s6_ax0  <= r_s5_ax0;
            r_s6_ay0  <= r_s5_ay0;
            r_s6_bx0  <= r_s5_bx0;

            r_s7_ax   <= r_s6_px[XW-1] ? -r_s6_px : r_s6_px;
            r_s7_ay   <= r_s6_py[XW-1] ? -r_s6_py : r_s6_py;
            r_s7_nx   <= r_s6_px[XW-1];
            r_s7_ny   <= r_s6_py[XW-1];
            r_s7_mden <= r_s6_mden;
            r_s7_hlim <= (XW'(r_s6_den) <<< FW) - r_s6_mden;
            r_s7_den  <= r_s6_den;
            r_s7_na   <= r_s6_na;
            r_s7_nb   <= r_s6_nb;
            r_s7_par  <= r_s6_par;
            r_s7_ax0  <= r_s6_ax0;
            r_s7_ay0  <= r_s6_ay0;
            r_s7_bx0  <= r_s6_bx0;

            r_s8_numx     <= w_numx;
            r_s8_numy     <= w_numy;
            r_s8_d        <= w_d;
            r_s8_nx       <= r_s7_nx;
            r_s8_ny       <= r_s7_ny;
            // quotient too large for the kept bits saturates for sure
            r_s8_ox       <= (w_numx >= w_dlim);
            r_s8_oy       <= (w_numy >= w_dlim);
            r_s8_side.par <= r_s7_par;
            r_s8_side.hit <= !r_s7_par
                             && (w_sna > r_s7_mden) && (w_sna < r_s7_hlim)
                             && (w_snb > r_s7_mden) && (w_snb < r_s7_hlim);
            r_s8_side.ax0 <= r_s7_ax0;
            r_s8_side.ay0 <= r_s7_ay0;
            r_s8_bx0      <= r_s7_bx0;
        end
    end

    sgi_pkg::t_coord w_div_x, w_div_y;

    sgi_rdiv u_div_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_num   (r_s8_numx),
        .i_den   (r_s8_d),
        .i_neg   (r_s8_nx),
        .i_ovf   (r_s8_ox),
        .i_base  (r_s8_bx0),
        .o_coord (w_div_x)
    );

    sgi_rdiv u_div_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_num   (r_s8_numy),
        .i_den   (r_s8_d),
        .i_neg   (r_s8_ny),
        .i_ovf   (r_s8_oy),
        .i_base  (r_s8_side.ay0),
        .o_coord (w_div_y)
    );

    // side band delay matched to the divider
    sgi_pkg::t_side r_side [ND];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r_s8_side;
            for (int k = 1; k < ND; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tuser  = {r_side[ND-1].par, r_side[ND-1].hit};
    assign o_m_axis_tdata  = r_side[ND-1].par
                             ? {r_side[ND-1].ay0, r_side[ND-1].ax0}
                             : {w_div_y, w_div_x};

    `SGI_ASSERT_NOW(a_hit_not_par, o_m_axis_tvalid,
        !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "hit reported on parallel lines")
    `SGI_ASSERT_NOW(a_ready_only_stall, !o_s_axis_tready,
        o_m_axis_tvalid && !i_m_axis_tready, "input stalled without output stall")
    `SGI_ASSERT_NEXT(a_accept_enters, i_s_axis_tvalid && o_s_axis_tready,
        r_v[0], "accepted beat did not enter the pipe")
    `SGI_ASSERT_NEXT(a_stall_holds, !w_adv,
        $stable(r_v) && $stable(r_side[ND-1]), "pipe moved during stall")

endmodule

@@ design/sgi_rdiv.sv @@
// ----------------------------------------------------------------------------
// sgi_rdiv
// pipelined rounding divider, one quotient bit per stage, adds a base and
// saturates the sum to the coordinate range
// ----------------------------------------------------------------------------
module sgi_rdiv (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  sgi_pkg::t_rem            i_num,     // 2*|x| + den
    input  logic [sgi_pkg::DNW-1:0]  i_den,     // 2*den
    input  logic                     i_neg,
    input  logic                     i_ovf,
    input  sgi_pkg::t_coord          i_base,
    output sgi_pkg::t_coord          o_coord
);

    localparam int QW = sgi_pkg::QW;
    localparam int RW = sgi_pkg::RW;
    localparam int SW = sgi_pkg::SW;

    sgi_pkg::t_rem            r_rem  [QW];
    logic [QW-1:0]            r_q    [QW];
    logic [sgi_pkg::DNW-1:0]  r_den  [QW];
    logic                     r_neg  [QW];
    logic                     r_ovf  [QW];
    sgi_pkg::t_coord          r_base [QW];
    sgi_pkg::t_coord          r_coord;

    for (genvar k = 0; k < QW; k++) begin : g_st
        sgi_pkg::t_rem            w_rem_in;
        logic [QW-1:0]            w_q_in;
        logic [sgi_pkg::DNW-1:0]  w_den_in;
        logic                     w_neg_in;
        logic                     w_ovf_in;
        sgi_pkg::t_coord          w_base_in;
        sgi_pkg::t_rem            w_dsh;
        logic                     w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_num;
            assign w_q_in    = '0;
            assign w_den_in  = i_den;
            assign w_neg_in  = i_neg;
            assign w_ovf_in  = i_ovf;
            assign w_base_in = i_base;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_q_in    = r_q[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_neg_in  = r_neg[k-1];
            assign w_ovf_in  = r_ovf[k-1];
            assign w_base_in = r_base[k-1];
        end

        assign w_dsh = RW'(w_den_in) << (QW - 1 - k);
        assign w_ge  = (w_rem_in >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_rem_in - w_dsh) : w_rem_in;
                r_q[k]    <= w_q_in | (w_ge ? (QW'(1) << (QW - 1 - k)) : '0);
                r_den[k]  <= w_den_in;
                r_neg[k]  <= w_neg_in;
                r_ovf[k]  <= w_ovf_in;
                r_base[k] <= w_base_in;
            end
        end
    end

    logic signed [SW-1:0] w_sq;
    logic signed [SW-1:0] w_sum;
    sgi_pkg::t_coord      n_coord;

    assign w_sq  = r_neg[QW-1] ? -$signed(SW'(r_q[QW-1])) : $signed(SW'(r_q[QW-1]));
    assign w_sum = SW'(r_base[QW-1]) + w_sq;

    always_comb begin
        if (r_ovf[QW-1]) begin
            n_coord = r_neg[QW-1] ? sgi_pkg::CMIN : sgi_pkg::CMAX;
        end else if (w_sum > SW'(sgi_pkg::CMAX)) begin
            n_coord = sgi_pkg::CMAX;
        end else if (w_sum < SW'(sgi_pkg::CMIN)) begin
            n_coord = sgi_pkg::CMIN;
        end else begin
            n_coord = w_sum[sgi_pkg::CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// segment intersection core testbench
// drives segment pairs and margin writes into the core, predicts every result
// with exact wide integer arithmetic, and compares each output beat in order
// ----------------------------------------------------------------------------
class crossing_scoreboard;
    typedef struct {
        logic         hit;
        logic         par;
        sgi_pkg::t_coord cx;
        sgi_pkg::t_coord cy;
    } t_crossing;

    t_crossing pending[$];
    logic [30:0] margin;
    int errors;
    int n_hits;
    int n_par;
    int n_checked;

    function new();
        margin = '0;
        errors = 0;
        n_hits = 0;
        n_par = 0;
        n_checked = 0;
    endfunction

    function sgi_pkg::t_coord clamp(logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = sgi_pkg::CMAX;
        lo = sgi_pkg::CMIN;
        if (v > hi) return sgi_pkg::CMAX;
        if (v < lo) return sgi_pkg::CMIN;
        return v[31:0];
    endfunction

    // strict margin < top/den < 1 - margin, den positive
    function logic inside_window(logic signed [127:0] top, logic signed [127:0] den);
        logic signed [127:0] scaled;
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        scaled = top <<< 32;
        lo = $signed({97'd0, margin}) * den;
        hi = ($signed(128'h1_0000_0000) - $signed({97'd0, margin})) * den;
        return (scaled > lo) && (scaled < hi);
    endfunction

    // rounded to nearest, ties away from zero
    function logic signed [127:0] round_div(logic signed [127:0] num,
                                            logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function void note_pair(logic [8*32-1:0] beat);
        sgi_pkg::t_coord c[8];
        logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        logic signed [127:0] dax, day, dbx, dby, wx, wy, den, num_a, num_b;
        t_crossing e;
        for (int i = 0; i < 8; i++) c[i] = beat[i*32 +: 32];
        ax0 = c[0]; ay0 = c[1]; ax1 = c[2]; ay1 = c[3];
        bx0 = c[4]; by0 = c[5]; bx1 = c[6]; by1 = c[7];
        dax = ax1 - ax0; day = ay1 - ay0;
        dbx = bx1 - bx0; dby = by1 - by0;
        wx = bx0 - ax0; wy = by0 - ay0;
        den = dbx * day - dax * dby;
        num_a = dbx * wy - wx * dby;
        num_b = dax * wy - wx * day;
        if (den == 0) begin
            e.hit = 1'b0;
            e.par = 1'b1;
            e.cx = c[0];
            e.cy = c[1];
        end else begin
            if (den < 0) begin
                den = -den;
                num_a = -num_a;
                num_b = -num_b;
            end
            e.hit = inside_window(num_a, den) && inside_window(num_b, den);
            e.par = 1'b0;
            e.cx = clamp(bx0 + round_div(dbx * num_b, den));
            e.cy = clamp(ay0 + round_div(day * num_a, den));
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] flags);
        t_crossing e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat tdata=%h tuser=%b", $time, data, flags);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (flags[0]) n_hits++;
        if (flags[1]) n_par++;
        if (flags[0] !== e.hit) begin
            $display("%0t: hit expected %b actual %b", $time, e.hit, flags[0]);
            errors++;
        end
        if (flags[1] !== e.par) begin
            $display("%0t: parallel expected %b actual %b", $time, e.par, flags[1]);
            errors++;
        end
        if (data[31:0] !== e.cx) begin
            $display("%0t: cross_x expected %h actual %h", $time, e.cx, data[31:0]);
            errors++;
        end
        if (data[63:32] !== e.cy) begin
            $display("%0t: cross_y expected %h actual %h", $time, e.cy, data[63:32]);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [255:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;
    logic [1:0]  m_user;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;

    int tx_idle_pct = 26;
    int rx_idle_pct = 53;
    int n_sent = 0;
    crossing_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    segment_intersection_2d_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),
        .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) sb.check_result(m_data, m_user);
    end

    task automatic send_pair(logic [255:0] beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge i_clk); while (!s_ready);
        sb.note_pair(beat);
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [30:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        sb.margin = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [255:0] pack(int c0, int c1, int c2, int c3,
                                          int c4, int c5, int c6, int c7);
        return {c7, c6, c5, c4, c3, c2, c1, c0};
    endfunction

    function automatic int small_coord();
        return $signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
    endfunction

    // mostly short segments near the origin so hits and misses both show up
    function automatic logic [255:0] random_pair();
        int k;
        int c[8];
        int dx;
        int dy;
        k = $urandom_range(9);
        for (int i = 0; i < 8; i++) c[i] = (k < 3) ? $urandom() : small_coord();
        if (k == 9) begin
            // parallel or collinear: B direction a multiple of A direction
            dx = $signed($urandom_range(2000)) - 1000;
            dy = $signed($urandom_range(2000)) - 1000;
            c[2] = c[0] + dx; c[3] = c[1] + dy;
            k = $signed($urandom_range(6)) - 3;
            c[6] = c[4] + k * dx; c[7] = c[5] + k * dy;
        end else if (k == 8) begin
            // nearly parallel long lines push the crossing out of range
            c[0] = $urandom(); c[1] = $urandom();
            c[2] = c[0] + 32'sh1000_0000; c[3] = c[1] + 1;
            c[4] = c[0] + small_coord(); c[5] = c[1] + small_coord();
            c[6] = c[4] + 32'sh1000_0000; c[7] = c[5];
        end
        return pack(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic directed_pairs();
        int mx;
        int mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_pair(pack(0, 0, 65536, 65536, 0, 65536, 65536, 0));       // plain cross
        send_pair(pack(mn, mn, mx, mx, mn, mx, mx, mn));               // full range cross
        send_pair(pack(mx, mn, mn, mx, mx, mx, mn, mn));
        send_pair(pack(mx, mx, mx, mx, mn, mn, mn, mn));               // zero length
        send_pair(pack(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(pack(0, 0, 65536, 0, 0, 65536, 65536, 65536));       // parallel
        send_pair(pack(0, 0, 65536, 0, 131072, 0, 196608, 0));         // collinear
        send_pair(pack(0, 0, 65536, 0, 0, 0, 0, 65536));               // touch at endpoint
        send_pair(pack(0, 0, 65536, 0, 65536, -5, 65536, 5));
        send_pair(pack(0, 0, 65536, 0, 200000, -5, 200000, 5));        // lines cross off segment
        send_pair(pack(mn, 0, mx, 1, mn, 0, mx, 0));                   // crossing at the shared start point
        send_pair(pack(mx, 0, mn, 1, mx, 0, mn, 0));
        send_pair(pack(0, mn, 1, mx, 0, mn, 0, mx));
        send_pair(pack(0, 0, 3, 0, 1, -1, 2, 1));                      // tie rounding
        send_pair(pack(0, 0, 65536, 65536, 0, 1, 65536, 65535));
        send_pair(pack(mx, mn, mx, mx, mn, 0, mx, 0));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_margin('0);
        directed_pairs();
        wait_drained();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_margin(31'h7FFF_FFFF);
                1: write_margin(31'h0000_0001);
                2: write_margin(31'h1000_0000);
                3: write_margin(31'h4000_0000);
                4: write_margin(31'($urandom()));
                default: write_margin('0);
            endcase
            if (phase < 2) begin
                tx_idle_pct = 26; rx_idle_pct = 53;
            end else if (phase < 4) begin
                tx_idle_pct = 53; rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (phase < 4) directed_pairs();
            for (int i = 0; i < 220; i++) begin
                send_pair(random_pair());
                if (phase == 1 && i == 100) wait_drained();   // sender holds off
            end
            wait_drained();
        end
        $display("covered %0d segment pairs over six margin settings: %0d hits, %0d parallel",
                 n_sent, sb.n_hits, sb.n_par);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
